// ===== rtl/kdb_pkg.sv =====
// Shared types and constants for the two-key debouncer with short/long press detection.
// No dependencies; imported by every module of the block.
package kdb_pkg;

    localparam int HISTORY_BITS = 8;
    localparam int KEY_COUNT    = 2;
    localparam int KEY_PORTS    = 2;
    localparam int CNT_W        = 8;
    localparam int LIMIT_W      = 8;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(80);
    localparam logic               REG_LIMIT   = 1'b0;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_key_evt;

    typedef struct packed {
        t_key_evt evt;
        logic     held;
    } t_lane_out;

endpackage

// ===== rtl/kdb_lane.sv =====
// One key lane: sample history, hold counter and press flags.
// Depends on kdb_pkg.
module kdb_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_level,
    input  logic [kdb_pkg::LIMIT_W-1:0]  i_limit,
    output kdb_pkg::t_lane_out           o_lane
);
    import kdb_pkg::*;

    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_pressed, n_pressed;
    logic                    r_long, n_long;
    t_key_evt                evt;

    always_comb begin
        n_hist    = {r_hist[HISTORY_BITS-2:0], i_level};
        n_cnt     = r_cnt;
        n_pressed = r_pressed;
        n_long    = r_long;
        evt       = EVT_NONE;
        if (n_hist == '0) begin
            n_pressed = 1'b1;
            if (!r_long) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end else if (r_pressed) begin
            if (!r_long) begin
                evt = EVT_SHORT;
            end
            n_pressed = 1'b0;
            n_long    = 1'b0;
            n_cnt     = '0;
        end
        if (n_cnt > i_limit) begin
            n_long = 1'b1;
            n_cnt  = '0;
            evt    = EVT_LONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist    <= '1;
            r_cnt     <= '0;
            r_pressed <= 1'b0;
            r_long    <= 1'b0;
        end else if (i_adv) begin
            r_hist    <= n_hist;
            r_cnt     <= n_cnt;
            r_pressed <= n_pressed;
            r_long    <= n_long;
        end
    end

    assign o_lane.evt  = evt;
    assign o_lane.held = n_pressed;

endmodule

// ===== rtl/kdb_merge.sv =====
// Merging stage: collects the lane results into one registered result transaction.
// Depends on kdb_pkg.
module kdb_merge (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_in_valid,
    output logic                                              o_in_ready,
    input  kdb_pkg::t_lane_out [kdb_pkg::KEY_PORTS-1:0]       i_lanes,
    output logic                                              o_out_valid,
    input  logic                                              i_out_ready,
    output kdb_pkg::t_lane_out [kdb_pkg::KEY_PORTS-1:0]       o_result
);
    import kdb_pkg::*;

    logic                         r_valid;
    t_lane_out [KEY_PORTS-1:0]    r_result;
    logic                         accept;

    assign o_in_ready = !r_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= i_lanes;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

// ===== rtl/key_debounce_short_long_press.sv =====
// Top level of the two-key debouncer: config register, key lanes and merging stage.
// Depends on kdb_pkg, kdb_lane and kdb_merge.
//
// Each accepted transaction carries one raw sample of both active-low keys and yields
// exactly one registered result transaction, holding per key a short/long press event
// and the debounced held flag. A new sample is taken every cycle the output is not
// stalled, also while the previous result waits in the output register, which frees
// itself as the result is taken. A key counts as pressed after HISTORY_BITS low samples
// in a row; a long press is reported once the hold count exceeds long_press_limit (APB
// offset 0x0, reset 80), a short press on release otherwise.
module key_debounce_short_long_press (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kdb_pkg::APB_AW-1:0]    paddr,
    input  logic [kdb_pkg::APB_DW-1:0]    pwdata,
    output logic [kdb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_key1_level,
    input  logic                          i_key2_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_key1_event,
    output logic [1:0]                    o_key2_event,
    output logic                          o_key1_held,
    output logic                          o_key2_held
);
    import kdb_pkg::*;

    logic [LIMIT_W-1:0]          r_limit;
    logic                        adv;
    logic [KEY_PORTS-1:0]        levels;
    t_lane_out [KEY_PORTS-1:0]   lanes;
    t_lane_out [KEY_PORTS-1:0]   result;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LIMIT) ? APB_DW'(r_limit) : '0;

    assign adv    = i_in_valid && o_in_ready;
    assign levels = {i_key2_level, i_key1_level};

    for (genvar k = 0; k < KEY_PORTS; k++) begin : g_lane
        if (k < KEY_COUNT) begin : g_on
            kdb_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_level (levels[k]),
                .i_limit (r_limit),
                .o_lane  (lanes[k])
            );
        end else begin : g_off
            assign lanes[k] = '{evt: EVT_NONE, held: 1'b0};
        end
    end

    kdb_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_lanes     (lanes),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_key1_event = result[0].evt;
    assign o_key2_event = result[1].evt;
    assign o_key1_held  = result[0].held;
    assign o_key2_held  = result[1].held;

endmodule

// ===== rtl/kdb_checker.sv =====
// Port-level checker for the two-key debouncer, bound to the top level.
// Depends on kdb_pkg and key_debounce_short_long_press.
module kdb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_key1_event,
    input  logic [1:0]  o_key2_event,
    input  logic        o_key1_held,
    input  logic        o_key2_held
);
    import kdb_pkg::*;

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

    a_long_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_key1_event == EVT_LONG) |-> o_key1_held)
        else $error("key one long press without held");

    a_short_means_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_key2_event == EVT_SHORT) |-> !o_key2_held)
        else $error("key two short press while held");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key1_event != 2'd3) && (o_key2_event != 2'd3))
        else $error("undefined event code");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key1_event)
            && $stable(o_key2_event) && $stable(o_key1_held) && $stable(o_key2_held))
        else $error("stalled result changed");

endmodule

bind key_debounce_short_long_press kdb_checker u_kdb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_key1_event (o_key1_event),
    .o_key2_event (o_key2_event),
    .o_key1_held  (o_key1_held),
    .o_key2_held  (o_key2_held)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for key_debounce_short_long_press: directed table, then random
// press/release scripts per key under random pacing and APB limit changes. Depends on
// kdb_pkg and the RTL top level; checks results against typed rows or the in-bench predictor.
module tb_top;
    import kdb_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int LATENCY        = 1;
    localparam int MAX_REPORTS    = 10;
    localparam int RX_HOLD_CYCLES = 160;
    localparam int PHASE_COUNT    = 8;
    localparam logic [APB_AW-1:0] LIMIT_ADDR = APB_AW'(4 * REG_LIMIT);

    typedef struct packed {
        t_lane_out k1;
        t_lane_out k2;
    } t_tick_res;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic               k1;
        logic               k2;
        int                 reps;
        bit                 typed;
        t_tick_res          exp;
        logic [LIMIT_W-1:0] lim;
    } t_dir_row;

    localparam t_tick_res RES_IDLE = '{k1: '{evt: EVT_NONE, held: 1'b0},
                                       k2: '{evt: EVT_NONE, held: 1'b0}};
    localparam t_tick_res RES_K1_HELD = '{k1: '{evt: EVT_NONE, held: 1'b1},
                                          k2: '{evt: EVT_NONE, held: 1'b0}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_key1_level;
    logic                  i_key2_level;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_key1_event;
    logic [1:0]            o_key2_event;
    logic                  o_key1_held;
    logic                  o_key2_held;

    logic [HISTORY_BITS-1:0] hist_q    [KEY_PORTS];
    logic [CNT_W-1:0]        hold_q    [KEY_PORTS];
    logic                    pressed_q [KEY_PORTS];
    logic                    long_q    [KEY_PORTS];
    logic [LIMIT_W-1:0]      limit_q;

    int        seg_left  [KEY_PORTS];
    logic      seg_level [KEY_PORTS];
    bit        seg_noise [KEY_PORTS];

    t_tick_res press_q [$];
    t_dir_row  dir_rows [$];
    t_tick_res cur_exp;
    bit        cur_typed;
    bit        pace_idle;
    bit        rx_hold_req;
    int        err_cnt;
    int        cycle_cnt;

    key_debounce_short_long_press u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_key1_level (i_key1_level),
        .i_key2_level (i_key2_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_key1_event (o_key1_event),
        .o_key2_event (o_key2_event),
        .o_key1_held  (o_key1_held),
        .o_key2_held  (o_key2_held)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic clear_key_state();
        for (int k = 0; k < KEY_PORTS; k++) begin
            hist_q[k]    = '1;
            hold_q[k]    = '0;
            pressed_q[k] = 1'b0;
            long_q[k]    = 1'b0;
        end
        limit_q = LIMIT_RESET;
    endtask

    function automatic t_key_evt debounce_key(int k, logic level);
        t_key_evt ev;
        ev = EVT_NONE;
        hist_q[k] = {hist_q[k][HISTORY_BITS-2:0], level};
        if (hist_q[k] == '0) begin
            pressed_q[k] = 1'b1;
            if (!long_q[k])
                hold_q[k] = hold_q[k] + 1'b1;
        end else if (pressed_q[k]) begin
            if (!long_q[k])
                ev = EVT_SHORT;
            pressed_q[k] = 1'b0;
            long_q[k]    = 1'b0;
            hold_q[k]    = '0;
        end
        if (hold_q[k] > limit_q) begin
            long_q[k] = 1'b1;
            hold_q[k] = '0;
            ev        = EVT_LONG;
        end
        return ev;
    endfunction

    function automatic t_tick_res predict_tick(logic k1, logic k2);
        t_tick_res r;
        r = RES_IDLE;
        if (KEY_COUNT > 0) begin
            r.k1.evt  = debounce_key(0, k1);
            r.k1.held = pressed_q[0];
        end
        if (KEY_COUNT > 1) begin
            r.k2.evt  = debounce_key(1, k2);
            r.k2.held = pressed_q[1];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int expv, int actv);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d", what, expv, actv);
    endtask

    always @(posedge i_clk) begin
        t_tick_res pred;
        t_tick_res want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pred = predict_tick(i_key1_level, i_key2_level);
            press_q.push_back(cur_typed ? cur_exp : pred);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (press_q.size() == 0) begin
                report_mismatch("unexpected transaction count", 0, 1);
            end else begin
                want = press_q.pop_front();
                if (o_key1_event !== want.k1.evt)
                    report_mismatch("key1_event", int'(want.k1.evt), int'(o_key1_event));
                if (o_key2_event !== want.k2.evt)
                    report_mismatch("key2_event", int'(want.k2.evt), int'(o_key2_event));
                if (o_key1_held !== want.k1.held)
                    report_mismatch("key1_held", int'(want.k1.held), int'(o_key1_held));
                if (o_key2_held !== want.k2.held)
                    report_mismatch("key2_held", int'(want.k2.held), int'(o_key2_held));
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    initial begin
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = RX_HOLD_CYCLES;
            end else if (stall == 0 && pace_idle) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_tick(logic k1, logic k2, bit typed, t_tick_res exp);
        int gap;
        gap = pace_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_key1_level = k1;
        i_key2_level = k2;
        cur_typed    = typed;
        cur_exp      = exp;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (press_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_access(bit wr, logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = LIMIT_ADDR;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] val);
        logic [APB_DW-1:0] rd;
        drain_results();
        apb_access(1'b1, APB_DW'(val), rd);
        limit_q = val;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DW'(val))
            report_mismatch("long_press_limit readback", int'(val), int'(rd));
    endtask

    function automatic logic next_level(int k, int lim);
        int r;
        if (seg_left[k] == 0) begin
            r = $urandom_range(0, 99);
            seg_noise[k] = 1'b0;
            if (r < 15) begin
                seg_noise[k] = 1'b1;
                seg_left[k]  = $urandom_range(1, 6);
            end else if (r < 55) begin
                seg_level[k] = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 40)
                    seg_left[k] = $urandom_range(5, 12);
                else if (r < 75)
                    seg_left[k] = HISTORY_BITS - 1 + lim + $urandom_range(0, 2);
                else
                    seg_left[k] = HISTORY_BITS - 1 + $urandom_range(1, lim + 10);
            end else begin
                seg_level[k] = 1'b1;
                seg_left[k]  = $urandom_range(1, 10);
            end
        end
        seg_left[k]--;
        return seg_noise[k] ? logic'($urandom_range(0, 1)) : seg_level[k];
    endfunction

    initial begin
        int phase_lim [PHASE_COUNT];
        int n_items;
        logic k1;
        logic k2;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_key1_level = 1'b1;
        i_key2_level = 1'b1;
        cur_typed    = 1'b0;
        cur_exp      = RES_IDLE;
        pace_idle    = 1'b1;
        rx_hold_req  = 1'b0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        clear_key_state();

        dir_rows.push_back('{ROW_ITEM, 1'b1, 1'b1, 2, 1'b1, RES_IDLE, '0});
        dir_rows.push_back('{ROW_CFG,  1'b1, 1'b1, 0, 1'b0, RES_IDLE, 8'd0});
        dir_rows.push_back('{ROW_ITEM, 1'b0, 1'b1, 8, 1'b0, RES_IDLE, '0});
        dir_rows.push_back('{ROW_ITEM, 1'b0, 1'b1, 2, 1'b1, RES_K1_HELD, '0});
        dir_rows.push_back('{ROW_ITEM, 1'b1, 1'b0, 1, 1'b0, RES_IDLE, '0});
        dir_rows.push_back('{ROW_ITEM, 1'b1, 1'b1, 1, 1'b0, RES_IDLE, '0});
        dir_rows.push_back('{ROW_CFG,  1'b1, 1'b1, 0, 1'b0, RES_IDLE, 8'd255});
        dir_rows.push_back('{ROW_ITEM, 1'b0, 1'b0, 9, 1'b0, RES_IDLE, '0});
        dir_rows.push_back('{ROW_ITEM, 1'b1, 1'b0, 1, 1'b0, RES_IDLE, '0});
        dir_rows.push_back('{ROW_ITEM, 1'b0, 1'b1, 3, 1'b0, RES_IDLE, '0});
        dir_rows.push_back('{ROW_ITEM, 1'b1, 1'b1, 1, 1'b0, RES_IDLE, '0});

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                set_limit(dir_rows[i].lim);
            end else begin
                repeat (dir_rows[i].reps)
                    send_tick(dir_rows[i].k1, dir_rows[i].k2, dir_rows[i].typed,
                              dir_rows[i].exp);
            end
        end

        phase_lim[0] = 0;
        phase_lim[1] = 1;
        phase_lim[2] = 3;
        phase_lim[3] = 80;
        phase_lim[4] = 254;
        phase_lim[5] = 255;
        phase_lim[6] = $urandom_range(2, 30);
        phase_lim[7] = $urandom_range(1, 254);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_limit(LIMIT_W'(phase_lim[p]));
            for (int k = 0; k < KEY_PORTS; k++) begin
                seg_left[k]  = 0;
                seg_level[k] = 1'b1;
                seg_noise[k] = 1'b0;
            end
            n_items = (phase_lim[p] > 100) ? 300 : ((phase_lim[p] > 40) ? 250 : 150);
            pace_idle = (p != 1) && ($urandom_range(0, 4) != 0);
            if (p == 2) begin
                pace_idle   = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (int i = 0; i < n_items; i++) begin
                k1 = next_level(0, phase_lim[p]);
                k2 = next_level(1, phase_lim[p]);
                send_tick(k1, k2, 1'b0, RES_IDLE);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end

        pace_idle = 1'b1;
        drain_results();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (err_cnt == 0 && press_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
